// ----- sv/sprite_frame_sequencer_unit_assert.svh -----
// Assertion macros shared by the sprite frame sequencer RTL.
`ifndef SPRITE_FRAME_SEQUENCER_UNIT_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on clk, skipped while rst is high.
`define SFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on clk at every edge, reset included.
`define SFS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SFS_ASSERT(label, prop, msg)
`define SFS_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- sv/sfs_pkg.sv -----
// Shared types and constants for the sprite frame sequencer.
package sfs_pkg;

  // Sequence limits
  localparam int MAX_FRAMES = 256;
  localparam int COUNT_W    = 9;
  localparam int FRAME_W    = 8;
  localparam int MS_W       = 16;
  localparam int ALPHA_W    = 8;
  localparam int FLAGS_W    = 4;

  // Stream payload widths
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 24;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_MS   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOOP_LIMIT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE_FLAGS    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FADE_STEP_MS  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_ALPHA = 3'd5;

  // Register reset values
  localparam logic [COUNT_W-1:0] FRAME_COUNT_RST   = 9'd0;
  localparam logic [MS_W-1:0]    INTERVAL_MS_RST   = 16'd1000;
  localparam logic [MS_W-1:0]    LOOP_LIMIT_RST    = 16'd1;
  localparam logic [FLAGS_W-1:0] MODE_FLAGS_RST    = 4'd2;
  localparam logic [MS_W-1:0]    FADE_STEP_MS_RST  = 16'd1;
  localparam logic [ALPHA_W-1:0] INITIAL_ALPHA_RST = 8'd255;

  // Mode flag bit positions
  localparam int FLAG_BOUNCE     = 0;
  localparam int FLAG_STOP_FIRST = 1;
  localparam int FLAG_AUTO_HIDE  = 2;
  localparam int FLAG_FADE       = 3;

  // Event kinds
  localparam logic [S_TUSER_W-1:0] KIND_TICK  = 3'd0;
  localparam logic [S_TUSER_W-1:0] KIND_PLAY  = 3'd1;
  localparam logic [S_TUSER_W-1:0] KIND_PAUSE = 3'd2;
  localparam logic [S_TUSER_W-1:0] KIND_STOP  = 3'd3;
  localparam logic [S_TUSER_W-1:0] KIND_RESET = 3'd4;

  // Shared divider
  localparam int DIVIDEND_W = 17;
  localparam int DIVISOR_W  = 16;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } div_rsp_t;

endpackage

// ----- sv/sprite_frame_sequencer_unit.sv -----
// Sprite frame sequencer: event-driven frame stepping, looping and alpha fade.
// Flow: an accepted event is latched and applied in the execute state, then registered out;
// a tick that reaches the fade step passes the fade state first, and a divide (play start
// index at or beyond the count, or a fade decrement) waits in the divide state for the shared divider.
// Events are taken one at a time, only while idle; a waiting result does not block the next event.
// Reset (rst, synchronous): registers to defaults, sequence stopped, alpha 255, sprite visible.
`include "sprite_frame_sequencer_unit_assert.svh"

module sprite_frame_sequencer_unit (
  input  logic                                clk,
  input  logic                                rst,
  // Event input
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [15:0] elapsed_ms, [16] keep_position, [17] reverse_dir, [33:18] start_index,
  // [34] rewind, [39:35] zero
  input  logic [sfs_pkg::S_TDATA_W-1:0]       s_tdata,
  // [2:0] kind
  input  logic [sfs_pkg::S_TUSER_W-1:0]       s_tuser,
  // Result output
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [7:0] frame_index, [15:8] alpha, [16] is_playing, [17] is_visible, [18] is_fading,
  // [23:19] zero
  output logic [sfs_pkg::M_TDATA_W-1:0]       m_tdata,
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_FADE = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;

  // Configuration registers
  logic [sfs_pkg::COUNT_W-1:0] frame_count;
  logic [sfs_pkg::MS_W-1:0]    interval_ms;
  logic [sfs_pkg::MS_W-1:0]    loop_limit;
  logic [sfs_pkg::FLAGS_W-1:0] mode_flags;
  logic [sfs_pkg::MS_W-1:0]    fade_step_ms;
  logic [sfs_pkg::ALPHA_W-1:0] initial_alpha;

  // Sequence state
  logic [sfs_pkg::FRAME_W-1:0] current_frame;
  logic [sfs_pkg::MS_W-1:0]    frame_time_ms;
  logic [sfs_pkg::MS_W-1:0]    loops_done;
  logic                        backward;
  logic                        running;
  logic                        fading;
  logic [sfs_pkg::MS_W-1:0]    fade_time_ms;
  logic [sfs_pkg::ALPHA_W-1:0] alpha_now;
  logic                        visible;

  // Latched event
  logic [sfs_pkg::S_TUSER_W-1:0] in_kind;
  logic [sfs_pkg::MS_W-1:0]      in_elapsed;
  logic                          in_keep;
  logic                          in_rev;
  logic [sfs_pkg::MS_W-1:0]      in_start;
  logic                          in_rewind;

  // Datapath helpers
  logic [sfs_pkg::COUNT_W-1:0] eff_n;
  logic [sfs_pkg::COUNT_W-1:0] last_frame;
  logic [sfs_pkg::MS_W:0]      frame_sum;
  logic                        interval_hit;
  logic                        at_end;
  logic [sfs_pkg::COUNT_W-1:0] step_frame;
  logic [sfs_pkg::COUNT_W-1:0] clamped_frame;
  logic [sfs_pkg::MS_W-1:0]    loops_inc;
  logic                        loop_again;
  logic [sfs_pkg::MS_W-1:0]    fade_step_eff;
  logic [sfs_pkg::MS_W:0]      fade_sum;
  logic                        fade_hit;
  logic [sfs_pkg::ALPHA_W-1:0] fade_dec;
  logic [sfs_pkg::ALPHA_W-1:0] alpha_left;
  logic                        play_div;
  logic                        fade_div;
  logic                        out_load;

  sfs_pkg::div_req_t div_req;
  sfs_pkg::div_rsp_t div_rsp;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state == S_OUT) && (!m_tvalid || m_tready);

  // Effective frame count, capped at the maximum
  assign eff_n = (frame_count > sfs_pkg::COUNT_W'(sfs_pkg::MAX_FRAMES))
               ? sfs_pkg::COUNT_W'(sfs_pkg::MAX_FRAMES) : frame_count;
  assign last_frame = eff_n - 1'b1;

  // Frame timing
  assign frame_sum    = {1'b0, frame_time_ms} + {1'b0, in_elapsed};
  assign interval_hit = frame_sum >= {1'b0, interval_ms};
  assign at_end       = backward ? (current_frame == '0)
                                 : ({1'b0, current_frame} == last_frame);
  assign step_frame   = backward ? ({1'b0, current_frame} - 1'b1)
                                 : ({1'b0, current_frame} + 1'b1);
  assign clamped_frame = (step_frame >= eff_n) ? last_frame : step_frame;

  // Loop counting, saturating
  assign loops_inc  = (loops_done == '1) ? loops_done : loops_done + 1'b1;
  assign loop_again = (loop_limit == '0) || (loops_inc < loop_limit);

  // Fade timing; a zero step acts as one millisecond
  assign fade_step_eff = (fade_step_ms == '0) ? sfs_pkg::MS_W'(1) : fade_step_ms;
  assign fade_sum      = {1'b0, fade_time_ms} + {1'b0, in_elapsed};
  assign fade_hit      = fade_sum >= {1'b0, fade_step_eff};
  assign fade_dec      = (|div_rsp.quotient[sfs_pkg::DIVIDEND_W-1:sfs_pkg::ALPHA_W])
                       ? '1 : div_rsp.quotient[sfs_pkg::ALPHA_W-1:0];
  assign alpha_left    = (alpha_now > fade_dec) ? (alpha_now - fade_dec) : '0;

  // Divider requests: start index modulo count, or fade decrement
  assign play_div = (state == S_EXEC) && (in_kind == sfs_pkg::KIND_PLAY) && !in_keep &&
                    (eff_n != '0) && (in_start >= {7'b0, eff_n});
  assign fade_div = (state == S_FADE) && fading && fade_hit;

  assign div_req.start    = play_div || fade_div;
  assign div_req.dividend = (state == S_EXEC) ? {1'b0, in_start} : fade_sum;
  assign div_req.divisor  = (state == S_EXEC) ? {7'b0, eff_n} : fade_step_eff;

  sfs_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Event latch
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind    <= s_tuser;
      in_elapsed <= s_tdata[15:0];
      in_keep    <= s_tdata[16];
      in_rev     <= s_tdata[17];
      in_start   <= s_tdata[33:18];
      in_rewind  <= s_tdata[34];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'b0, fading, visible, running, alpha_now, current_frame};
    end
  end

  // Configuration, sequencer and sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      frame_count   <= sfs_pkg::FRAME_COUNT_RST;
      interval_ms   <= sfs_pkg::INTERVAL_MS_RST;
      loop_limit    <= sfs_pkg::LOOP_LIMIT_RST;
      mode_flags    <= sfs_pkg::MODE_FLAGS_RST;
      fade_step_ms  <= sfs_pkg::FADE_STEP_MS_RST;
      initial_alpha <= sfs_pkg::INITIAL_ALPHA_RST;
      current_frame <= '0;
      frame_time_ms <= '0;
      loops_done    <= '0;
      backward      <= 1'b0;
      running       <= 1'b0;
      fading        <= 1'b0;
      fade_time_ms  <= '0;
      alpha_now     <= sfs_pkg::INITIAL_ALPHA_RST;
      visible       <= 1'b1;
    end else begin
      // Register writes
      if (cfg_valid) begin
        unique case (cfg_index)
          sfs_pkg::REG_FRAME_COUNT:   frame_count   <= cfg_data[sfs_pkg::COUNT_W-1:0];
          sfs_pkg::REG_INTERVAL_MS:   interval_ms   <= cfg_data;
          sfs_pkg::REG_LOOP_LIMIT:    loop_limit    <= cfg_data;
          sfs_pkg::REG_MODE_FLAGS:    mode_flags    <= cfg_data[sfs_pkg::FLAGS_W-1:0];
          sfs_pkg::REG_FADE_STEP_MS:  fade_step_ms  <= cfg_data;
          sfs_pkg::REG_INITIAL_ALPHA: initial_alpha <= cfg_data[sfs_pkg::ALPHA_W-1:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_EXEC;
          end
        end

        // Apply the event; a tick handles frame stepping here
        S_EXEC: begin
          state <= S_OUT;
          unique case (in_kind)
            sfs_pkg::KIND_TICK: begin
              if (running && (eff_n > sfs_pkg::COUNT_W'(1))) begin
                state <= S_FADE;
                if (interval_hit) begin
                  frame_time_ms <= '0;
                  if (!at_end) begin
                    current_frame <= clamped_frame[sfs_pkg::FRAME_W-1:0];
                  end else begin
                    loops_done <= loops_inc;
                    if (loop_again) begin
                      if (mode_flags[sfs_pkg::FLAG_BOUNCE]) begin
                        current_frame <= (current_frame == '0)
                                       ? '0 : last_frame[sfs_pkg::FRAME_W-1:0];
                        backward      <= !backward;
                      end else begin
                        current_frame <= (current_frame == '0)
                                       ? last_frame[sfs_pkg::FRAME_W-1:0] : '0;
                      end
                    end else begin
                      // End of the last loop: fade or reset
                      if (mode_flags[sfs_pkg::FLAG_FADE]) begin
                        fading <= 1'b1;
                      end else begin
                        running    <= 1'b0;
                        loops_done <= '0;
                        fading     <= 1'b0;
                        alpha_now  <= initial_alpha;
                        if (mode_flags[sfs_pkg::FLAG_STOP_FIRST]) begin
                          current_frame <= '0;
                        end
                      end
                      if (mode_flags[sfs_pkg::FLAG_AUTO_HIDE] &&
                          !mode_flags[sfs_pkg::FLAG_FADE]) begin
                        visible <= 1'b0;
                      end
                    end
                  end
                end else begin
                  frame_time_ms <= frame_sum[sfs_pkg::MS_W-1:0];
                end
              end
            end
            sfs_pkg::KIND_PLAY: begin
              running  <= 1'b1;
              backward <= in_rev;
              if (!in_keep) begin
                if (eff_n == '0) begin
                  current_frame <= '0;
                end else if (play_div) begin
                  state <= S_DIV;
                end else begin
                  current_frame <= in_start[sfs_pkg::FRAME_W-1:0];
                end
              end
            end
            sfs_pkg::KIND_PAUSE: begin
              running <= 1'b0;
            end
            sfs_pkg::KIND_STOP: begin
              if (mode_flags[sfs_pkg::FLAG_FADE]) begin
                fading <= 1'b1;
              end else begin
                running       <= 1'b0;
                loops_done    <= '0;
                frame_time_ms <= '0;
                fading        <= 1'b0;
                alpha_now     <= initial_alpha;
                if (in_rewind) begin
                  current_frame <= '0;
                end
              end
            end
            sfs_pkg::KIND_RESET: begin
              running       <= 1'b0;
              loops_done    <= '0;
              frame_time_ms <= '0;
              fading        <= 1'b0;
              alpha_now     <= initial_alpha;
              if (in_rewind) begin
                current_frame <= '0;
              end
            end
            default: ;
          endcase
        end

        // Fade time accumulation; a full step starts the divide
        S_FADE: begin
          if (fade_div) begin
            state <= S_DIV;
          end else begin
            if (fading) begin
              fade_time_ms <= fade_sum[sfs_pkg::MS_W-1:0];
            end
            state <= S_OUT;
          end
        end

        // Wait for the divider, then apply its result
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_OUT;
            if (in_kind == sfs_pkg::KIND_PLAY) begin
              current_frame <= div_rsp.remainder[sfs_pkg::FRAME_W-1:0];
            end else begin
              fade_time_ms <= '0;
              alpha_now    <= alpha_left;
              if (alpha_left == '0) begin
                running       <= 1'b0;
                loops_done    <= '0;
                frame_time_ms <= '0;
                fading        <= 1'b0;
                if (mode_flags[sfs_pkg::FLAG_STOP_FIRST]) begin
                  current_frame <= '0;
                end
                if (mode_flags[sfs_pkg::FLAG_AUTO_HIDE]) begin
                  visible <= 1'b0;
                end
              end
            end
          end
        end

        // Hand the result to the output register once it is free
        S_OUT: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SFS_ASSERT(a_accept_exec, s_tvalid && s_tready |=> state == S_EXEC, "transfer did not start execution")
  `SFS_ASSERT_ALWAYS(a_rst_clean, rst |=> !m_tvalid && state == S_IDLE, "reset left a result or busy state")
  `SFS_ASSERT(a_div_done_state, div_rsp.done |-> state == S_DIV, "divider finished outside the wait state")
  `SFS_ASSERT(a_out_wait, state == S_OUT && m_tvalid && !m_tready |=> state == S_OUT, "result dropped while output stalled")

endmodule

// ----- sv/sfs_divider.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
`include "sprite_frame_sequencer_unit_assert.svh"

module sfs_divider (
  input  logic             clk,
  input  logic             rst,
  input  sfs_pkg::div_req_t req,
  output sfs_pkg::div_rsp_t rsp
);

  logic                               busy;
  logic                               done;
  logic [sfs_pkg::DIV_CNT_W-1:0]      count;
  logic [sfs_pkg::DIVISOR_W-1:0]      rem;
  logic [sfs_pkg::DIVIDEND_W-1:0]     quo;
  logic [sfs_pkg::DIVISOR_W-1:0]      divisor;

  logic [sfs_pkg::DIVIDEND_W-1:0]     trial;
  logic [sfs_pkg::DIVIDEND_W-1:0]     diff;
  logic                               fits;
  logic [sfs_pkg::DIVISOR_W-1:0]      rem_next;

  // Shift in the next dividend bit and try the subtract
  assign trial    = {rem, quo[sfs_pkg::DIVIDEND_W-1]};
  assign diff     = trial - {1'b0, divisor};
  assign fits     = trial >= {1'b0, divisor};
  assign rem_next = fits ? diff[sfs_pkg::DIVISOR_W-1:0] : trial[sfs_pkg::DIVISOR_W-1:0];

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == sfs_pkg::DIV_CNT_W'(sfs_pkg::DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[sfs_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

  `SFS_ASSERT(a_start_busy, req.start |=> busy, "divider did not go busy after start")
  `SFS_ASSERT(a_done_after_busy, rsp.done |-> !busy && $past(busy), "divider done without a run")
  `SFS_ASSERT(a_rem_range, rsp.done |-> rem < divisor, "divider remainder not below divisor")

endmodule
